// ===== src/itrn_pkg.sv =====
// ----------------------------------------------------------------------------
// itrn_pkg
// shared types and constants for the integer to roman numeral converter
// ----------------------------------------------------------------------------
package itrn_pkg;

  localparam int VALUE_W  = 12;
  localparam int SYMBOL_W = 7;
  localparam int STATUS_W = 2;
  localparam int UPC_W    = 3;

  localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

  localparam logic [STATUS_W-1:0] ST_CHAR = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER = 2'd2;

  localparam logic [SYMBOL_W-1:0] CH_NONE = 7'd0;
  localparam logic [SYMBOL_W-1:0] CH_I    = 7'd73;
  localparam logic [SYMBOL_W-1:0] CH_V    = 7'd86;
  localparam logic [SYMBOL_W-1:0] CH_X    = 7'd88;
  localparam logic [SYMBOL_W-1:0] CH_L    = 7'd76;
  localparam logic [SYMBOL_W-1:0] CH_C    = 7'd67;
  localparam logic [SYMBOL_W-1:0] CH_D    = 7'd68;
  localparam logic [SYMBOL_W-1:0] CH_M    = 7'd77;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_NONE,
    OP_DIGIT,
    OP_EMIT,
    OP_REPORT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_BAD,
    C_DIG_ZERO,
    C_PAT_MORE,
    C_REM_ZERO
  } csel_t;

  typedef struct packed {
    op_t              op;
    csel_t            cond;
    logic [UPC_W-1:0] tgt_t;
    logic [UPC_W-1:0] tgt_f;
  } ucw_t;

  typedef struct packed {
    op_t  op;
    logic go;
  } ctl_t;

  typedef struct packed {
    logic accept;
    logic bad;
    logic dig_zero;
    logic pat_more;
    logic rem_zero;
    logic emit_ok;
  } flags_t;

endpackage

// ===== src/itrn_seq.sv =====
// ----------------------------------------------------------------------------
// itrn_seq
// microcode sequencer: control store, step counter and branch select
// ----------------------------------------------------------------------------
module itrn_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  itrn_pkg::flags_t flags,
  output itrn_pkg::ctl_t   ctl
);
  import itrn_pkg::*;

  localparam logic [UPC_W-1:0] S_WAIT   = 3'd0;
  localparam logic [UPC_W-1:0] S_CHECK  = 3'd1;
  localparam logic [UPC_W-1:0] S_DIGIT  = 3'd2;
  localparam logic [UPC_W-1:0] S_EMIT   = 3'd3;
  localparam logic [UPC_W-1:0] S_SKIP   = 3'd4;
  localparam logic [UPC_W-1:0] S_REPORT = 3'd5;

  function automatic ucw_t rom(input logic [UPC_W-1:0] addr);
    ucw_t w;
    unique case (addr)
      S_WAIT:   w = '{op: OP_LOAD,   cond: C_ACCEPT,   tgt_t: S_CHECK,  tgt_f: S_WAIT};
      S_CHECK:  w = '{op: OP_NONE,   cond: C_BAD,      tgt_t: S_REPORT, tgt_f: S_DIGIT};
      S_DIGIT:  w = '{op: OP_DIGIT,  cond: C_DIG_ZERO, tgt_t: S_SKIP,   tgt_f: S_EMIT};
      S_EMIT:   w = '{op: OP_EMIT,   cond: C_PAT_MORE, tgt_t: S_EMIT,   tgt_f: S_DIGIT};
      S_SKIP:   w = '{op: OP_NONE,   cond: C_REM_ZERO, tgt_t: S_WAIT,   tgt_f: S_DIGIT};
      S_REPORT: w = '{op: OP_REPORT, cond: C_ALWAYS,   tgt_t: S_WAIT,   tgt_f: S_WAIT};
      default:  w = '{op: OP_NONE,   cond: C_ALWAYS,   tgt_t: S_WAIT,   tgt_f: S_WAIT};
    endcase
    return w;
  endfunction

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  ucw_t             ucw;
  logic             take;
  logic             go;

  assign ucw = rom(upc_r);

  always_comb begin
    unique case (ucw.cond)
      C_ALWAYS:   take = 1'b1;
      C_ACCEPT:   take = flags.accept;
      C_BAD:      take = flags.bad;
      C_DIG_ZERO: take = flags.dig_zero;
      C_PAT_MORE: take = flags.pat_more;
      C_REM_ZERO: take = flags.rem_zero;
      default:    take = 1'b1;
    endcase
  end

  // output steps wait for room in the output register
  assign go      = (ucw.op == OP_EMIT || ucw.op == OP_REPORT) ? flags.emit_ok : 1'b1;
  assign upc_nxt = go ? (take ? ucw.tgt_t : ucw.tgt_f) : upc_r;

  assign ctl.op = ucw.op;
  assign ctl.go = go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    ((ucw.op == OP_EMIT || ucw.op == OP_REPORT) && !flags.emit_ok) |=> $stable(upc_r))
    else $error("step advanced while output blocked");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    flags.accept |=> (upc_r == S_CHECK))
    else $error("accepted item did not reach range check");

  a_accept_wait: assert property (@(posedge clk) disable iff (!rst_n)
    flags.accept |-> (upc_r == S_WAIT))
    else $error("item accepted outside wait step");

endmodule

// ===== src/itrn_dp.sv =====
// ----------------------------------------------------------------------------
// itrn_dp
// datapath: digit split by place, letter pattern lookup, output register
// ----------------------------------------------------------------------------
module itrn_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  itrn_pkg::ctl_t                   ctl,
  output itrn_pkg::flags_t                 flags,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [itrn_pkg::VALUE_W-1:0]     in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [itrn_pkg::SYMBOL_W-1:0]    out_symbol,
  output logic                             out_last,
  output logic [itrn_pkg::STATUS_W-1:0]    out_status
);
  import itrn_pkg::*;

  localparam logic [1:0] PAT_UNIT = 2'd0;
  localparam logic [1:0] PAT_FIVE = 2'd1;
  localparam logic [1:0] PAT_NEXT = 2'd2;

  function automatic logic [2:0] pat_len(input logic [3:0] d);
    logic [2:0] n;
    unique case (d)
      4'd1, 4'd5:        n = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:              n = 3'd2;
      4'd3, 4'd7:        n = 3'd3;
      4'd8:              n = 3'd4;
      default:           n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] pat_off(input logic [3:0] d, input logic [1:0] pos);
    logic [1:0] o;
    unique case (d)
      4'd4:              o = (pos == 2'd0) ? PAT_UNIT : PAT_FIVE;
      4'd5:              o = PAT_FIVE;
      4'd6, 4'd7, 4'd8:  o = (pos == 2'd0) ? PAT_FIVE : PAT_UNIT;
      4'd9:              o = (pos == 2'd0) ? PAT_UNIT : PAT_NEXT;
      default:           o = PAT_UNIT;
    endcase
    return o;
  endfunction

  function automatic logic [SYMBOL_W-1:0] letter(input logic [3:0] idx);
    logic [SYMBOL_W-1:0] c;
    unique case (idx)
      4'd0:              c = CH_I;
      4'd1:              c = CH_V;
      4'd2:              c = CH_X;
      4'd3:              c = CH_L;
      4'd4:              c = CH_C;
      4'd5:              c = CH_D;
      4'd6, 4'd7, 4'd8:  c = CH_M;
      default:           c = CH_NONE;
    endcase
    return c;
  endfunction

  logic [VALUE_W-1:0]  rem_r;
  logic [1:0]          place_r;
  logic [1:0]          dplace_r;
  logic [3:0]          digit_r;
  logic [1:0]          pos_r;
  logic                bad_r;
  logic                zero_r;
  logic                out_valid_r;
  logic [SYMBOL_W-1:0] out_symbol_r;
  logic                out_last_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                accept;
  logic [9:0]          pw;
  logic [13:0]         thr;
  logic [3:0]          dig;
  logic [VALUE_W-1:0]  sub;
  logic [2:0]          len;
  logic                pat_more;
  logic [3:0]          idx;
  logic [SYMBOL_W-1:0] sym;
  logic                emit_fire;

  assign in_stall = (ctl.op != OP_LOAD);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    unique case (place_r)
      2'd0:    pw = 10'd1;
      2'd1:    pw = 10'd10;
      2'd2:    pw = 10'd100;
      default: pw = 10'd1000;
    endcase
  end

  // thresholds rise with k, so the last one met gives the digit
  always_comb begin
    dig = 4'd0;
    sub = '0;
    thr = '0;
    for (int k = 1; k <= 9; k++) begin
      thr = 14'(k) * {4'd0, pw};
      if ({2'd0, rem_r} >= thr) begin
        dig = 4'(k);
        sub = thr[VALUE_W-1:0];
      end
    end
  end

  assign len      = pat_len(digit_r);
  assign pat_more = ({1'b0, pos_r} + 3'd1) < len;
  assign idx      = {1'b0, dplace_r, 1'b0} + {2'd0, pat_off(digit_r, pos_r)};
  assign sym      = letter(idx);

  assign emit_fire = ctl.go && (ctl.op == OP_EMIT || ctl.op == OP_REPORT);

  assign flags.accept   = accept;
  assign flags.bad      = bad_r;
  assign flags.dig_zero = (dig == 4'd0);
  assign flags.pat_more = pat_more;
  assign flags.rem_zero = (rem_r == '0);
  assign flags.emit_ok  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      rem_r   <= in_value;
      place_r <= 2'd3;
      zero_r  <= (in_value == '0);
      bad_r   <= (in_value == '0) || (in_value > MAX_VALUE);
    end else if (ctl.go && ctl.op == OP_DIGIT) begin
      rem_r    <= rem_r - sub;
      digit_r  <= dig;
      dplace_r <= place_r;
      place_r  <= place_r - 2'd1;
      pos_r    <= 2'd0;
    end else if (emit_fire && ctl.op == OP_EMIT) begin
      pos_r <= pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      if (ctl.op == OP_EMIT) begin
        out_symbol_r <= sym;
        out_last_r   <= !pat_more && (rem_r == '0);
        out_status_r <= ST_CHAR;
      end else begin
        out_symbol_r <= CH_NONE;
        out_last_r   <= 1'b1;
        out_status_r <= zero_r ? ST_ZERO : ST_OVER;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_CHAR) |-> (out_last_r && out_symbol_r == CH_NONE))
    else $error("status item carries a letter or lacks last");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("second item taken while converting");

  a_letter_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_CHAR) |->
      (out_symbol_r == CH_I || out_symbol_r == CH_V || out_symbol_r == CH_X ||
       out_symbol_r == CH_L || out_symbol_r == CH_C || out_symbol_r == CH_D ||
       out_symbol_r == CH_M))
    else $error("character item is not a numeral letter");

endmodule

// ===== src/integer_to_roman_numeral.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// converts a 12-bit unsigned value to its subtractive roman numeral in ascii
// ----------------------------------------------------------------------------
// Each input item is one value; the block answers with one output item per
// numeral letter, most significant first, with last set on the final letter.
// Zero answers with a single item of status 1 and values above 3999 with a
// single item of status 2, both with symbol 0. One item is converted at a
// time: a six-step microcode program checks the range, then walks the
// decimal places, splitting off each digit, emitting each letter in its own
// step once the output register has room, passing a zero place through the
// skip step, and ending when the remainder is empty; zero and out-of-range
// values go to the report step. 3888 (MMMDCCCLXXXVIII) has the longest
// numeral. The next item is taken once the program is back in its wait step;
// a finished letter can sit in the output register meanwhile.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [itrn_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [itrn_pkg::SYMBOL_W-1:0] out_symbol,
  output logic                          out_last,
  output logic [itrn_pkg::STATUS_W-1:0] out_status
);
  import itrn_pkg::*;

  ctl_t   ctl;
  flags_t flags;

  itrn_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  itrn_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .flags      (flags),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule

// ===== dv/tb_integer_to_roman_numeral.sv =====
// ----------------------------------------------------------------------------
// tb_integer_to_roman_numeral
// self-checking bench for the integer to roman numeral converter
// ----------------------------------------------------------------------------
// Values go in through the valid/stall input port and every accepted value is
// expanded into its expected letters by a behavioral model of subtractive
// numerals. Each letter that leaves the block is checked field by field
// against the oldest expected letter. Directed values cover zero, the range
// limits, out-of-range values and every subtractive pair. A burst is drained
// completely before sending resumes. Random values then run with random
// sender gaps and receiver stalls, except for one stretch with neither.
// ----------------------------------------------------------------------------
module tb_integer_to_roman_numeral;
  timeunit 1ns;
  timeprecision 1ps;

  import itrn_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTS   = 20;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic [STATUS_W-1:0] status;
  } roman_letter_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [VALUE_W-1:0]  in_value  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SYMBOL_W-1:0] out_symbol;
  logic                out_last;
  logic [STATUS_W-1:0] out_status;

  roman_letter_t expected_letters[$];
  roman_letter_t oldest_letter;
  int            mismatches = 0;
  int            cycles     = 0;
  int            stall_left = 0;
  bit            no_idle    = 1'b0;

  integer_to_roman_numeral dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .out_status (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // expand one value into the letters of its numeral, or a status item for zero and out-of-range values
  function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
    logic [SYMBOL_W-1:0] unit_ch [4];
    logic [SYMBOL_W-1:0] five_ch [4];
    logic [SYMBOL_W-1:0] letters[$];
    int                  rest;
    int                  digit;
    int                  k;
    roman_letter_t       item;
    unit_ch = '{CH_I, CH_X, CH_C, CH_M};
    five_ch = '{CH_V, CH_L, CH_D, CH_M};
    rest = int'(v);
    if (v == '0) begin
      item = '{symbol: CH_NONE, last: 1'b1, status: ST_ZERO};
      expected_letters.push_back(item);
      return;
    end
    if (v > MAX_VALUE) begin
      item = '{symbol: CH_NONE, last: 1'b1, status: ST_OVER};
      expected_letters.push_back(item);
      return;
    end
    for (int p = 3; p >= 0; p--) begin
      digit = (rest / (10 ** p)) % 10;
      if (digit == 9) begin
        letters.push_back(unit_ch[p]);
        letters.push_back(unit_ch[p + 1]);
      end else if (digit == 4) begin
        letters.push_back(unit_ch[p]);
        letters.push_back(five_ch[p]);
      end else begin
        if (digit >= 5) letters.push_back(five_ch[p]);
        for (k = 0; k < digit % 5; k++) letters.push_back(unit_ch[p]);
      end
    end
    foreach (letters[i]) begin
      item = '{symbol: letters[i], last: (i == letters.size() - 1), status: ST_CHAR};
      expected_letters.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_letters.size() == 0) begin
        report_mismatch($sformatf("unexpected item symbol=%0d last=%0b status=%0d",
                                  out_symbol, out_last, out_status));
      end else begin
        oldest_letter = expected_letters.pop_front();
        if (out_symbol !== oldest_letter.symbol)
          report_mismatch($sformatf("symbol %0d, expected %0d",
                                    out_symbol, oldest_letter.symbol));
        if (out_last !== oldest_letter.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_last, oldest_letter.last));
        if (out_status !== oldest_letter.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_status, oldest_letter.status));
      end
      stall_left = draw_wait();
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    predict_numeral(v);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_letters.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return VALUE_W'($urandom_range(0, 4095));
    if (pick == 1) return ($urandom_range(0, 3) == 0) ? '0 : VALUE_W'($urandom_range(4000, 4095));
    return VALUE_W'($urandom_range(1, 3999));
  endfunction

  // zero, range limits, out of range, longest numeral
  task automatic test_range_extremes();
    send_value(12'd0);
    send_value(12'd1);
    send_value(12'd3999);
    send_value(12'd4000);
    send_value(12'd4095);
    send_value(12'd2048);
    send_value(12'd3888);
    send_value(12'd5);
    send_value(12'd8);
  endtask

  // every subtractive pair at every place
  task automatic test_subtractive_pairs();
    send_value(12'd4);
    send_value(12'd9);
    send_value(12'd40);
    send_value(12'd90);
    send_value(12'd400);
    send_value(12'd900);
    send_value(12'd1994);
    send_value(12'd3449);
    send_value(12'd1000);
    send_value(12'd555);
  endtask

  // burst, full drain, then resume
  task automatic test_drain_between_bursts();
    repeat (12) send_value(random_value());
    wait_for_drain();
    repeat (8) send_value(random_value());
  endtask

  task automatic test_random_values();
    no_idle = 1'b1;
    repeat (30) send_value(random_value());
    no_idle = 1'b0;
    repeat (80) send_value(random_value());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_range_extremes();
    test_subtractive_pairs();
    test_drain_between_bursts();
    test_random_values();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
